// ===== rtl/best_fit_heap_allocator_top_defines.svh =====
// assertion macros for the allocator rtl
`ifndef BEST_FIT_HEAP_ALLOCATOR_TOP_DEFINES_SVH
`define BEST_FIT_HEAP_ALLOCATOR_TOP_DEFINES_SVH

// condition that holds at every clock edge out of reset
`define BFHA_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// condition that implies another in the next cycle
`define BFHA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/bfha_pkg.sv =====
// shared types and constants of the best-fit heap allocator
package bfha_pkg;

    localparam int HEADER_BYTES = 24;
    localparam int FREE_ENTRIES = 64;
    localparam int LIVE_ENTRIES = 64;
    localparam int HEAP_BYTES   = 1048576;

    localparam int WORD_W  = 21;
    localparam int SUM_W   = WORD_W + 3;
    localparam int FREE_AW = $clog2(FREE_ENTRIES);
    localparam int FREE_CW = $clog2(FREE_ENTRIES + 1);
    localparam int LIVE_AW = $clog2(LIVE_ENTRIES);
    localparam int LIVE_CW = $clog2(LIVE_ENTRIES + 1);
    localparam int IDX_W   = (FREE_CW > LIVE_CW) ? FREE_CW : LIVE_CW;
    localparam int BLK_W   = 2 * WORD_W;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [SUM_W-1:0]  sum_t;

    localparam sum_t  HDR      = SUM_W'(HEADER_BYTES);
    localparam sum_t  HDR2     = SUM_W'(2 * HEADER_BYTES);
    localparam word_t HEAP_MAX = WORD_W'(HEAP_BYTES);

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_HEAP  = 2'd1,
        ST_BAD_FREE = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef struct packed {
        word_t start;
        word_t bytes;
    } blk_t;

    typedef struct packed {
        word_t   addr;
        status_t status;
    } res_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_AL_SCAN,
        S_AL_DECIDE,
        S_SHIFT_DN,
        S_FR_LIVE,
        S_FR_SCAN,
        S_FR_DECIDE,
        S_SHIFT_UP,
        S_DONE
    } ctrl_state_t;

    // zero-extend a word to arithmetic width
    function automatic sum_t ext(input word_t w);
        return {{(SUM_W - WORD_W){1'b0}}, w};
    endfunction

endpackage

// ===== rtl/bfha_ram.sv =====
// generic simple dual-port ram with registered read
module bfha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/bfha_ctrl.sv =====
// sequencer and datapath that walk the free and live tables
`include "best_fit_heap_allocator_top_defines.svh"
module bfha_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   opcode,
    input  bfha_pkg::word_t        request_size,
    input  bfha_pkg::word_t        payload_address,
    input  bfha_pkg::word_t        limit,
    output logic                   res_valid,
    input  logic                   res_ready,
    output bfha_pkg::res_t         res
);

    bfha_pkg::ctrl_state_t state_reg, state_next;

    bfha_pkg::word_t req_reg, req_next;
    bfha_pkg::word_t paddr_reg, paddr_next;
    logic [bfha_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic [bfha_pkg::IDX_W-1:0] chk_idx_reg, chk_idx_next;
    logic chk_reg, chk_next;
    logic found_reg, found_next;
    logic [bfha_pkg::FREE_AW-1:0] best_idx_reg, best_idx_next;
    bfha_pkg::blk_t best_reg, best_next;
    logic [bfha_pkg::LIVE_AW-1:0] slot_reg, slot_next;
    bfha_pkg::blk_t blk_reg, blk_next;
    logic [bfha_pkg::FREE_CW-1:0] pos_reg, pos_next;
    bfha_pkg::blk_t prev_reg, prev_next;
    bfha_pkg::blk_t cur_reg, cur_next;
    logic [bfha_pkg::FREE_CW-1:0] free_count_reg, free_count_next;
    bfha_pkg::word_t heap_top_reg, heap_top_next;
    logic [bfha_pkg::LIVE_ENTRIES-1:0] live_valid_reg, live_valid_next;
    bfha_pkg::word_t res_addr_reg, res_addr_next;
    bfha_pkg::status_t res_status_reg, res_status_next;

    logic free_we;
    logic [bfha_pkg::FREE_AW-1:0] free_wa, free_ra;
    bfha_pkg::blk_t free_wd, fr_q;
    logic live_we;
    logic [bfha_pkg::LIVE_AW-1:0] live_wa, live_ra;
    bfha_pkg::blk_t live_wd, lv_q;

    logic [bfha_pkg::LIVE_AW-1:0] slot_free;
    logic [bfha_pkg::IDX_W-1:0] count_x;

    // free-block table, address ordered
    bfha_ram #(
        .WIDTH (bfha_pkg::BLK_W),
        .DEPTH (bfha_pkg::FREE_ENTRIES)
    ) u_free_ram (
        .clk     (clk),
        .we      (free_we),
        .wr_addr (free_wa),
        .wr_data (free_wd),
        .rd_addr (free_ra),
        .rd_data (fr_q)
    );

    // live-block table
    bfha_ram #(
        .WIDTH (bfha_pkg::BLK_W),
        .DEPTH (bfha_pkg::LIVE_ENTRIES)
    ) u_live_ram (
        .clk     (clk),
        .we      (live_we),
        .wr_addr (live_wa),
        .wr_data (live_wd),
        .rd_addr (live_ra),
        .rd_data (lv_q)
    );

    // lowest unused live slot
    always_comb
    begin
        slot_free = '0;
        for (int i = bfha_pkg::LIVE_ENTRIES - 1; i >= 0; i--)
        begin
            if (!live_valid_reg[i])
            begin
                slot_free = bfha_pkg::LIVE_AW'(i);
            end
        end
    end

    assign count_x   = bfha_pkg::IDX_W'(free_count_reg);
    assign in_ready  = (state_reg == bfha_pkg::S_IDLE);
    assign res.addr   = res_addr_reg;
    assign res.status = res_status_reg;

    // control state and flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bfha_pkg::S_IDLE;
            chk_reg        <= 1'b0;
            found_reg      <= 1'b0;
            free_count_reg <= '0;
            heap_top_reg   <= '0;
            live_valid_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            chk_reg        <= chk_next;
            found_reg      <= found_next;
            free_count_reg <= free_count_next;
            heap_top_reg   <= heap_top_next;
            live_valid_reg <= live_valid_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        paddr_reg      <= paddr_next;
        idx_reg        <= idx_next;
        chk_idx_reg    <= chk_idx_next;
        best_idx_reg   <= best_idx_next;
        best_reg       <= best_next;
        slot_reg       <= slot_next;
        blk_reg        <= blk_next;
        pos_reg        <= pos_next;
        prev_reg       <= prev_next;
        cur_reg        <= cur_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
    end

    // next state, table accesses and result
    always_comb
    begin
        logic            stop;
        logic            split;
        logic            adj_l;
        logic            adj_r;
        bfha_pkg::sum_t  grow;
        bfha_pkg::word_t g_start;
        bfha_pkg::word_t g_bytes;

        stop    = 1'b0;
        split   = 1'b0;
        adj_l   = 1'b0;
        adj_r   = 1'b0;
        grow    = '0;
        g_start = '0;
        g_bytes = '0;

        state_next      = state_reg;
        req_next        = req_reg;
        paddr_next      = paddr_reg;
        idx_next        = idx_reg;
        chk_idx_next    = chk_idx_reg;
        chk_next        = chk_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_next       = best_reg;
        slot_next       = slot_reg;
        blk_next        = blk_reg;
        pos_next        = pos_reg;
        prev_next       = prev_reg;
        cur_next        = cur_reg;
        free_count_next = free_count_reg;
        heap_top_next   = heap_top_reg;
        live_valid_next = live_valid_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;

        free_we  = 1'b0;
        free_wa  = '0;
        free_wd  = '0;
        free_ra  = idx_reg[bfha_pkg::FREE_AW-1:0];
        live_we  = 1'b0;
        live_wa  = slot_reg;
        live_wd  = '0;
        live_ra  = idx_reg[bfha_pkg::LIVE_AW-1:0];
        res_valid = 1'b0;

        unique case (state_reg)
            bfha_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next        = request_size;
                    paddr_next      = payload_address;
                    idx_next        = '0;
                    chk_next        = 1'b0;
                    found_next      = 1'b0;
                    res_addr_next   = '0;
                    res_status_next = bfha_pkg::ST_OK;
                    if (opcode == bfha_pkg::OP_ALLOC)
                    begin
                        if (&live_valid_reg)
                        begin
                            res_status_next = bfha_pkg::ST_FULL;
                            state_next      = bfha_pkg::S_DONE;
                        end
                        else
                        begin
                            slot_next  = slot_free;
                            state_next = bfha_pkg::S_AL_SCAN;
                        end
                    end
                    else
                    begin
                        state_next = bfha_pkg::S_FR_LIVE;
                    end
                end
            end

            // best-fit search, one entry per cycle
            bfha_pkg::S_AL_SCAN:
            begin
                if (chk_reg)
                begin
                    if (fr_q.bytes == req_reg)
                    begin
                        best_idx_next = chk_idx_reg[bfha_pkg::FREE_AW-1:0];
                        best_next     = fr_q;
                        found_next    = 1'b1;
                        stop          = 1'b1;
                        chk_next      = 1'b0;
                        state_next    = bfha_pkg::S_AL_DECIDE;
                    end
                    else if (fr_q.bytes > req_reg &&
                             (!found_reg || fr_q.bytes < best_reg.bytes))
                    begin
                        best_idx_next = chk_idx_reg[bfha_pkg::FREE_AW-1:0];
                        best_next     = fr_q;
                        found_next    = 1'b1;
                    end
                end
                if (!stop)
                begin
                    if (idx_reg < count_x)
                    begin
                        chk_next     = 1'b1;
                        chk_idx_next = idx_reg;
                        idx_next     = idx_reg + 1'b1;
                    end
                    else
                    begin
                        chk_next = 1'b0;
                        if (!chk_reg)
                        begin
                            state_next = bfha_pkg::S_AL_DECIDE;
                        end
                    end
                end
            end

            // split, take whole, or grow the heap; report out of heap past the limit
            bfha_pkg::S_AL_DECIDE:
            begin
                split = (bfha_pkg::ext(best_reg.bytes) + bfha_pkg::HDR) >=
                        ((bfha_pkg::HDR + bfha_pkg::ext(req_reg)) << 1);
                grow  = bfha_pkg::ext(heap_top_reg) + bfha_pkg::HDR + bfha_pkg::ext(req_reg);
                state_next = bfha_pkg::S_DONE;
                if (found_reg)
                begin
                    if (split)
                    begin
                        g_start = bfha_pkg::WORD_W'(bfha_pkg::ext(best_reg.start) +
                                  bfha_pkg::ext(best_reg.bytes) - bfha_pkg::ext(req_reg));
                        g_bytes = req_reg;
                        free_we       = 1'b1;
                        free_wa       = best_idx_reg;
                        free_wd.start = best_reg.start;
                        free_wd.bytes = bfha_pkg::WORD_W'(bfha_pkg::ext(best_reg.bytes) -
                                        bfha_pkg::ext(req_reg) - bfha_pkg::HDR);
                    end
                    else
                    begin
                        g_start    = best_reg.start;
                        g_bytes    = best_reg.bytes;
                        idx_next   = bfha_pkg::IDX_W'(best_idx_reg) + 1'b1;
                        chk_next   = 1'b0;
                        state_next = bfha_pkg::S_SHIFT_DN;
                    end
                end
                else
                begin
                    g_start = heap_top_reg;
                    g_bytes = req_reg;
                end
                if (!found_reg && grow > bfha_pkg::ext(limit))
                begin
                    res_status_next = bfha_pkg::ST_NO_HEAP;
                end
                else
                begin
                    if (!found_reg)
                    begin
                        heap_top_next = bfha_pkg::WORD_W'(grow);
                    end
                    live_we                   = 1'b1;
                    live_wa                   = slot_reg;
                    live_wd.start             = g_start;
                    live_wd.bytes             = g_bytes;
                    live_valid_next[slot_reg] = 1'b1;
                    res_addr_next = bfha_pkg::WORD_W'(bfha_pkg::ext(g_start) + bfha_pkg::HDR);
                    res_status_next = bfha_pkg::ST_OK;
                end
            end

            // close a gap: move entries one place down
            bfha_pkg::S_SHIFT_DN:
            begin
                if (chk_reg)
                begin
                    free_we = 1'b1;
                    free_wa = bfha_pkg::FREE_AW'(chk_idx_reg - 1'b1);
                    free_wd = fr_q;
                end
                if (idx_reg < count_x)
                begin
                    chk_next     = 1'b1;
                    chk_idx_next = idx_reg;
                    idx_next     = idx_reg + 1'b1;
                end
                else
                begin
                    chk_next = 1'b0;
                    if (!chk_reg)
                    begin
                        free_count_next = free_count_reg - 1'b1;
                        state_next      = bfha_pkg::S_DONE;
                    end
                end
            end

            // find the live block being freed
            bfha_pkg::S_FR_LIVE:
            begin
                if (chk_reg && live_valid_reg[chk_idx_reg[bfha_pkg::LIVE_AW-1:0]] &&
                    (bfha_pkg::ext(lv_q.start) + bfha_pkg::HDR) == bfha_pkg::ext(paddr_reg))
                begin
                    slot_next  = chk_idx_reg[bfha_pkg::LIVE_AW-1:0];
                    blk_next   = lv_q;
                    idx_next   = '0;
                    chk_next   = 1'b0;
                    state_next = bfha_pkg::S_FR_SCAN;
                end
                else if (idx_reg < bfha_pkg::IDX_W'(bfha_pkg::LIVE_ENTRIES))
                begin
                    chk_next     = 1'b1;
                    chk_idx_next = idx_reg;
                    idx_next     = idx_reg + 1'b1;
                end
                else
                begin
                    chk_next = 1'b0;
                    if (!chk_reg)
                    begin
                        res_status_next = bfha_pkg::ST_BAD_FREE;
                        state_next      = bfha_pkg::S_DONE;
                    end
                end
            end

            // find the insert position and both neighbours
            bfha_pkg::S_FR_SCAN:
            begin
                if (chk_reg)
                begin
                    if (fr_q.start > blk_reg.start)
                    begin
                        pos_next   = bfha_pkg::FREE_CW'(chk_idx_reg);
                        cur_next   = fr_q;
                        stop       = 1'b1;
                        chk_next   = 1'b0;
                        state_next = bfha_pkg::S_FR_DECIDE;
                    end
                    else
                    begin
                        prev_next = fr_q;
                    end
                end
                if (!stop)
                begin
                    if (idx_reg < count_x)
                    begin
                        chk_next     = 1'b1;
                        chk_idx_next = idx_reg;
                        idx_next     = idx_reg + 1'b1;
                    end
                    else
                    begin
                        chk_next = 1'b0;
                        if (!chk_reg)
                        begin
                            pos_next   = free_count_reg;
                            state_next = bfha_pkg::S_FR_DECIDE;
                        end
                    end
                end
            end

            // coalesce or insert; report a full table when no room is left
            bfha_pkg::S_FR_DECIDE:
            begin
                adj_l = (pos_reg != '0) &&
                        ((bfha_pkg::ext(prev_reg.start) + bfha_pkg::HDR +
                          bfha_pkg::ext(prev_reg.bytes)) == bfha_pkg::ext(blk_reg.start));
                adj_r = (pos_reg != free_count_reg) &&
                        ((bfha_pkg::ext(blk_reg.start) + bfha_pkg::HDR +
                          bfha_pkg::ext(blk_reg.bytes)) == bfha_pkg::ext(cur_reg.start));
                state_next = bfha_pkg::S_DONE;
                if (adj_l && adj_r)
                begin
                    free_we       = 1'b1;
                    free_wa       = bfha_pkg::FREE_AW'(pos_reg - 1'b1);
                    free_wd.start = prev_reg.start;
                    free_wd.bytes = bfha_pkg::WORD_W'(bfha_pkg::ext(prev_reg.bytes) +
                                    bfha_pkg::HDR2 + bfha_pkg::ext(blk_reg.bytes) +
                                    bfha_pkg::ext(cur_reg.bytes));
                    live_valid_next[slot_reg] = 1'b0;
                    idx_next   = bfha_pkg::IDX_W'(pos_reg) + 1'b1;
                    chk_next   = 1'b0;
                    state_next = bfha_pkg::S_SHIFT_DN;
                end
                else if (adj_l)
                begin
                    free_we       = 1'b1;
                    free_wa       = bfha_pkg::FREE_AW'(pos_reg - 1'b1);
                    free_wd.start = prev_reg.start;
                    free_wd.bytes = bfha_pkg::WORD_W'(bfha_pkg::ext(prev_reg.bytes) +
                                    bfha_pkg::HDR + bfha_pkg::ext(blk_reg.bytes));
                    live_valid_next[slot_reg] = 1'b0;
                end
                else if (adj_r)
                begin
                    free_we       = 1'b1;
                    free_wa       = pos_reg[bfha_pkg::FREE_AW-1:0];
                    free_wd.start = blk_reg.start;
                    free_wd.bytes = bfha_pkg::WORD_W'(bfha_pkg::ext(cur_reg.bytes) +
                                    bfha_pkg::HDR + bfha_pkg::ext(blk_reg.bytes));
                    live_valid_next[slot_reg] = 1'b0;
                end
                else if (free_count_reg >= bfha_pkg::FREE_CW'(bfha_pkg::FREE_ENTRIES))
                begin
                    res_status_next = bfha_pkg::ST_FULL;
                end
                else
                begin
                    idx_next   = count_x;
                    chk_next   = 1'b0;
                    state_next = bfha_pkg::S_SHIFT_UP;
                end
            end

            // open a gap: move entries one place up, top first
            bfha_pkg::S_SHIFT_UP:
            begin
                if (chk_reg)
                begin
                    free_we = 1'b1;
                    free_wa = bfha_pkg::FREE_AW'(chk_idx_reg + 1'b1);
                    free_wd = fr_q;
                end
                if (idx_reg > bfha_pkg::IDX_W'(pos_reg))
                begin
                    free_ra      = bfha_pkg::FREE_AW'(idx_reg - 1'b1);
                    chk_next     = 1'b1;
                    chk_idx_next = idx_reg - 1'b1;
                    idx_next     = idx_reg - 1'b1;
                end
                else
                begin
                    chk_next = 1'b0;
                    if (!chk_reg)
                    begin
                        free_we         = 1'b1;
                        free_wa         = pos_reg[bfha_pkg::FREE_AW-1:0];
                        free_wd         = blk_reg;
                        free_count_next = free_count_reg + 1'b1;
                        live_valid_next[slot_reg] = 1'b0;
                        state_next      = bfha_pkg::S_DONE;
                    end
                end
            end

            bfha_pkg::S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = bfha_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = bfha_pkg::S_IDLE;
            end
        endcase
    end

    // checks
    `BFHA_ASSERT_ALWAYS(a_count_range, free_count_reg <= bfha_pkg::FREE_CW'(bfha_pkg::FREE_ENTRIES), "free count past table size")
    `BFHA_ASSERT_ALWAYS(a_heap_bound, heap_top_reg <= bfha_pkg::HEAP_MAX, "heap top past heap size")
    `BFHA_ASSERT_ALWAYS(a_no_idle_write, !((free_we || live_we) && state_reg == bfha_pkg::S_IDLE), "table write while idle")
    `BFHA_ASSERT_NEXT(a_result_hold, state_reg == bfha_pkg::S_DONE && !res_ready, state_reg == bfha_pkg::S_DONE && $stable(res_addr_reg), "result dropped while stalled")

endmodule

// ===== rtl/best_fit_heap_allocator_top.sv =====
// best-fit heap allocator top level: limit register, output register
//
// Input channel (in_valid/in_ready) takes one word: opcode 0 allocates
// request_size payload bytes, opcode 1 frees payload_address. Each word
// gives exactly one result word on out_valid/out_ready: result_address
// (granted payload address, zero on failure) and status (0 ok, 1 out of
// heap, 2 unknown free, 3 table full).
// Items are handled one at a time. An allocate scans the free table for the
// best fit, then shifts entries down when a whole block leaves the free
// table. A free scans the live table for its entry (one entry per
// cycle through the live table port), then scans the free table to place
// it, and may shift entries up or down. The single read port of each table
// sets the pace.
// A finished result sits in the output register; the next word is taken
// while it waits, and the one after that waits until the receiver takes it.
// cfg_we writes heap_limit at once. Reset empties both tables, sets the
// heap top to zero and the limit to the full heap; no clearing pass.
module best_fit_heap_allocator_top (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    opcode,
    input  logic [20:0]             request_size,
    input  logic [20:0]             payload_address,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [20:0]             result_address,
    output logic [1:0]              status,
    input  logic                    cfg_we,
    input  logic [20:0]             cfg_wdata
);

    bfha_pkg::word_t heap_limit_reg;
    bfha_pkg::word_t limit_eff;
    logic            out_valid_reg;
    bfha_pkg::res_t  out_reg;
    logic            res_valid;
    logic            res_ready;
    bfha_pkg::res_t  res;

    // limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_limit_reg <= bfha_pkg::HEAP_MAX;
        end
        else if (cfg_we)
        begin
            heap_limit_reg <= cfg_wdata;
        end
    end

    assign limit_eff = (heap_limit_reg < bfha_pkg::HEAP_MAX) ? heap_limit_reg
                                                              : bfha_pkg::HEAP_MAX;

    bfha_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .opcode          (opcode),
        .request_size    (request_size),
        .payload_address (payload_address),
        .limit           (limit_eff),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .res             (res)
    );

    // output register
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_address = out_reg.addr;
    assign status         = out_reg.status;

endmodule

// ===== tb/sv/tb.sv =====
// testbench for the best-fit heap allocator: directed table, then random words
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bfha_pkg::*;

    localparam int unsigned ADDR_MASK = 32'h1F_FFFF;
    localparam int          LONG_HOLD = 400;
    localparam int          SETTLE    = 250;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    in_valid = 1'b0;
    logic    in_ready;
    logic    opcode = OP_ALLOC;
    word_t   request_size = '0;
    word_t   payload_address = '0;
    logic    out_valid;
    logic    out_ready = 1'b0;
    word_t   result_address;
    logic [1:0] status;
    logic    cfg_we = 1'b0;
    word_t   cfg_wdata = '0;

    best_fit_heap_allocator_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .opcode          (opcode),
        .request_size    (request_size),
        .payload_address (payload_address),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .result_address  (result_address),
        .status          (status),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata)
    );

    // one directed row: typed result only where it is obvious
    typedef struct {
        logic    op;
        word_t   req;
        word_t   addr;
        bit      typed;
        word_t   exp_addr;
        status_t exp_status;
    } step_row_t;

    // shadow allocator state
    int unsigned hole_start [FREE_ENTRIES];
    int unsigned hole_bytes [FREE_ENTRIES];
    int unsigned hole_count;
    int unsigned grant_start [LIVE_ENTRIES];
    int unsigned grant_bytes [LIVE_ENTRIES];
    bit          grant_used  [LIVE_ENTRIES];
    int unsigned brk;
    int unsigned limit_reg;

    res_t pending_results [$];
    int   mismatches = 0;
    bit   sender_idles = 1'b1;
    bit   receiver_stalls = 1'b1;
    bit   hold_request = 1'b0;

    step_row_t steps [21] = '{
        '{OP_FREE,  21'd0,        21'd24,       1'b1, 21'd0,  ST_BAD_FREE},
        '{OP_ALLOC, 21'd0,        21'd0,        1'b1, 21'd24, ST_OK},
        '{OP_ALLOC, 21'd100,      21'd0,        1'b1, 21'd48, ST_OK},
        '{OP_ALLOC, 21'd1048576,  21'd0,        1'b1, 21'd0,  ST_NO_HEAP},
        '{OP_ALLOC, 21'h1F_FFFF,  21'd0,        1'b1, 21'd0,  ST_NO_HEAP},
        '{OP_FREE,  21'd0,        21'd48,       1'b1, 21'd0,  ST_OK},
        '{OP_FREE,  21'd0,        21'd48,       1'b1, 21'd0,  ST_BAD_FREE},
        '{OP_FREE,  21'd0,        21'd0,        1'b1, 21'd0,  ST_BAD_FREE},
        '{OP_FREE,  21'h1F_FFFF,  21'h1F_FFFF,  1'b1, 21'd0,  ST_BAD_FREE},
        '{OP_ALLOC, 21'd100,      21'd0,        1'b1, 21'd48, ST_OK},
        '{OP_ALLOC, 21'd200,      21'd0,        1'b0, 21'd0,  ST_OK},
        '{OP_ALLOC, 21'd50,       21'd0,        1'b0, 21'd0,  ST_OK},
        '{OP_ALLOC, 21'd30,       21'd0,        1'b0, 21'd0,  ST_OK},
        '{OP_FREE,  21'd0,        21'd172,      1'b0, 21'd0,  ST_OK},
        '{OP_ALLOC, 21'd20,       21'd0,        1'b0, 21'd0,  ST_OK},
        '{OP_FREE,  21'd0,        21'd396,      1'b0, 21'd0,  ST_OK},
        '{OP_FREE,  21'd0,        21'd352,      1'b0, 21'd0,  ST_OK},
        '{OP_FREE,  21'd0,        21'd24,       1'b0, 21'd0,  ST_OK},
        '{OP_ALLOC, 21'd0,        21'd0,        1'b0, 21'd0,  ST_OK},
        '{OP_FREE,  21'd0,        21'd470,      1'b0, 21'd0,  ST_OK},
        '{OP_ALLOC, 21'd5000,     21'd0,        1'b0, 21'd0,  ST_OK}
    };

    // clock
    always #5 clk = ~clk;

    // run limit
    initial
    begin
        #10ms;
        $display("FAILURE");
        $finish;
    end

    // drop a hole from the shadow free list
    function automatic void hole_drop(input int unsigned pos);
        for (int unsigned i = pos; i + 1 < hole_count; i++)
        begin
            hole_start[i] = hole_start[i+1];
            hole_bytes[i] = hole_bytes[i+1];
        end
        if (hole_count > 0)
            hole_count--;
    endfunction

    // best-fit allocation on the shadow state
    function automatic status_t shadow_alloc(input int unsigned req, output int unsigned addr);
        int          slot = -1;
        int unsigned best = 0;
        bit          found = 1'b0;
        int unsigned fsz, start, bytes, lim;
        addr = 0;
        for (int i = 0; i < LIVE_ENTRIES; i++)
        begin
            if (!grant_used[i])
            begin
                slot = i;
                break;
            end
        end
        if (slot < 0)
            return ST_FULL;
        for (int unsigned i = 0; i < hole_count; i++)
        begin
            if (hole_bytes[i] >= req)
            begin
                if (hole_bytes[i] == req)
                begin
                    best = i;
                    found = 1'b1;
                    break;
                end
                if (!found || hole_bytes[i] < hole_bytes[best])
                begin
                    best = i;
                    found = 1'b1;
                end
            end
        end
        if (found)
        begin
            fsz = hole_bytes[best];
            if (fsz + HEADER_BYTES >= 2 * (HEADER_BYTES + req))
            begin
                start = hole_start[best] + (fsz - req);
                bytes = req;
                hole_bytes[best] = fsz - req - HEADER_BYTES;
            end
            else
            begin
                start = hole_start[best];
                bytes = fsz;
                hole_drop(best);
            end
        end
        else
        begin
            lim = (limit_reg < HEAP_BYTES) ? limit_reg : HEAP_BYTES;
            if (brk + HEADER_BYTES + req > lim)
                return ST_NO_HEAP;
            start = brk;
            bytes = req;
            brk = brk + HEADER_BYTES + req;
        end
        grant_start[slot] = start;
        grant_bytes[slot] = bytes;
        grant_used[slot] = 1'b1;
        addr = (start + HEADER_BYTES) & ADDR_MASK;
        return ST_OK;
    endfunction

    // release with address-ordered insert and coalescing
    function automatic status_t shadow_release(input int unsigned paddr);
        int          slot = -1;
        int unsigned pos, start, bytes;
        bit          left_adj = 1'b0, right_adj = 1'b0;
        for (int i = 0; i < LIVE_ENTRIES; i++)
        begin
            if (grant_used[i] && grant_start[i] + HEADER_BYTES == paddr)
            begin
                slot = i;
                break;
            end
        end
        if (slot < 0)
            return ST_BAD_FREE;
        start = grant_start[slot];
        bytes = grant_bytes[slot];
        pos = hole_count;
        for (int unsigned i = 0; i < hole_count; i++)
        begin
            if (hole_start[i] > start)
            begin
                pos = i;
                break;
            end
        end
        if (pos > 0 && hole_start[pos-1] + HEADER_BYTES + hole_bytes[pos-1] == start)
            left_adj = 1'b1;
        if (pos < hole_count && start + HEADER_BYTES + bytes == hole_start[pos])
            right_adj = 1'b1;
        if (left_adj && right_adj)
        begin
            hole_bytes[pos-1] += 2 * HEADER_BYTES + bytes + hole_bytes[pos];
            hole_drop(pos);
        end
        else if (left_adj)
            hole_bytes[pos-1] += HEADER_BYTES + bytes;
        else if (right_adj)
        begin
            hole_bytes[pos] += HEADER_BYTES + bytes;
            hole_start[pos] = start;
        end
        else
        begin
            if (hole_count >= FREE_ENTRIES)
                return ST_FULL;
            for (int unsigned i = hole_count; i > pos; i--)
            begin
                hole_start[i] = hole_start[i-1];
                hole_bytes[i] = hole_bytes[i-1];
            end
            hole_start[pos] = start;
            hole_bytes[pos] = bytes;
            hole_count++;
        end
        grant_used[slot] = 1'b0;
        return ST_OK;
    endfunction

    // expected result of one word, updating the shadow state
    function automatic res_t predict_result(input logic op, input word_t req, input word_t paddr);
        res_t        r;
        int unsigned a = 0;
        if (op == OP_ALLOC)
            r.status = shadow_alloc(req, a);
        else
            r.status = shadow_release(paddr);
        r.addr = (r.status == ST_OK) ? word_t'(a) : '0;
        return r;
    endfunction

    // offer one word and log its expected result on acceptance
    task automatic send_word(input logic op, input word_t req, input word_t paddr,
                             input bit typed, input res_t typed_res);
        res_t r;
        if (sender_idles && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        request_size <= req;
        payload_address <= paddr;
        do @(posedge clk); while (!in_ready);
        r = predict_result(op, req, paddr);
        pending_results.push_back(typed ? typed_res : r);
    endtask

    // stop offering and wait until every result has come back
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    // heap limit write while idle
    task automatic write_limit(input int unsigned v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= word_t'(v);
        @(posedge clk);
        cfg_we <= 1'b0;
        limit_reg = v & ADDR_MASK;
    endtask

    // one random word, mostly well-formed traffic
    task automatic random_word(input bit fill_mode);
        int          r = $urandom_range(0, 99);
        int          live_ids [$];
        int unsigned req;
        res_t        none = '{addr: '0, status: ST_OK};
        for (int i = 0; i < LIVE_ENTRIES; i++)
            if (grant_used[i])
                live_ids.push_back(i);
        if (r < (fill_mode ? 75 : 45) || (r < 85 && live_ids.size() == 0))
        begin
            // ordinary allocate, sometimes an exact hole size
            if (hole_count > 0 && $urandom_range(0, 3) == 0)
                req = hole_bytes[$urandom_range(0, hole_count - 1)];
            else if ($urandom_range(0, 1) == 0)
                req = $urandom_range(0, 64);
            else
                req = $urandom_range(0, 600);
            send_word(OP_ALLOC, word_t'(req), word_t'($urandom), 1'b0, none);
        end
        else if (r < 85)
            send_word(OP_FREE, word_t'($urandom),
                      word_t'(grant_start[live_ids[$urandom_range(0, live_ids.size() - 1)]]
                              + HEADER_BYTES), 1'b0, none);
        else if (r < 90)
            send_word(OP_ALLOC, word_t'($urandom_range(0, 21'h1F_FFFF)),
                      word_t'($urandom), 1'b0, none);
        else if (r < 96)
            send_word(OP_FREE, word_t'($urandom), word_t'($urandom_range(0, 21'h1F_FFFF)),
                      1'b0, none);
        else
            // off-by-one address near a live block
            send_word(OP_FREE, word_t'($urandom),
                      word_t'((live_ids.size() ? grant_start[live_ids[0]] : 0)
                              + HEADER_BYTES + 1), 1'b0, none);
    endtask

    // result checker
    always @(posedge clk)
    begin
        res_t exp_res;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: addr %0d status %0d",
                             result_address, status);
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (result_address !== exp_res.addr || status !== exp_res.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected addr %0d status %0d, got addr %0d status %0d",
                                 exp_res.addr, exp_res.status, result_address, status);
                end
            end
        end
    end

    // receiver: random stalls and one long hold-off
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_request = 1'b0;
            end
            else if (receiver_stalls && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // reset, stimulus and final verdict
    initial
    begin
        int unsigned limits [6];
        res_t        typed_res;
        limits = '{HEAP_BYTES, 4096, 0, 20000, $urandom_range(0, HEAP_BYTES), HEAP_BYTES};
        hole_count = 0;
        brk = 0;
        limit_reg = HEAP_BYTES;
        for (int i = 0; i < LIVE_ENTRIES; i++)
            grant_used[i] = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        write_limit(HEAP_BYTES);
        foreach (steps[i])
        begin
            typed_res.addr = steps[i].exp_addr;
            typed_res.status = steps[i].exp_status;
            send_word(steps[i].op, steps[i].req, steps[i].addr, steps[i].typed, typed_res);
        end

        // random phases across heap limits
        for (int p = 0; p < 6; p++)
        begin
            write_limit(limits[p]);
            if (p == 5)
            begin
                sender_idles = 1'b0;
                receiver_stalls = 1'b0;
            end
            if (p == 1)
                hold_request = 1'b1;
            for (int n = 0; n < 300; n++)
            begin
                if (p == 3 && n == 150)
                    drain();
                random_word((n / 60) % 2 == 1);
            end
        end

        drain();
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
